// ----- design/deg_pkg.sv -----
// ----------------------------------------------------------------------------
// deg_pkg
// Shared types and constants for the dual epsilon-greedy bandit.
// ----------------------------------------------------------------------------
package deg_pkg;

  localparam int unsigned ValW  = 40;  // Q24.16 table entry
  localparam int unsigned StepW = 24;  // Q0.24 step and decay
  localparam int unsigned EpsW  = 16;  // Q0.16 threshold and draw
  localparam int unsigned CntW  = 24;  // cell count
  localparam int unsigned CfgW  = 24;  // widest configuration register
  localparam int unsigned MulW  = 24;  // shared multiplier operand width

  localparam logic [CntW-1:0]  CellCountMax = {CntW{1'b1}};
  localparam logic [CntW-1:0]  CellCountInc = CntW'(2);
  localparam logic [StepW-1:0] InitStepRst  = StepW'(1677722);
  localparam logic [EpsW-1:0]  ExploreRst   = EpsW'(3277);
  localparam logic [StepW-1:0] DecayRst     = StepW'(16775538);

  // Configuration register indexes.
  localparam logic [1:0] CfgInitialStep     = 2'd0;
  localparam logic [1:0] CfgExploreThreshold = 2'd1;
  localparam logic [1:0] CfgStepDecay       = 2'd2;

  // Input command codes.
  localparam logic [1:0] CmdExpand      = 2'd0;
  localparam logic [1:0] CmdSizeCheck   = 2'd1;
  localparam logic [1:0] CmdChangeCheck = 2'd2;

  localparam logic TblExplore = 1'b0;
  localparam logic TblExploit = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_MLO,
    ST_UPD_MHI,
    ST_UPD_SUM,
    ST_UPD_WR,
    ST_DECAY_MUL,
    ST_DECAY_WR,
    ST_PICK,
    ST_SCAN,
    ST_DONE
  } deg_state_e;

endpackage

// ----- design/dual_epsilon_greedy_bandit.sv -----
// ----------------------------------------------------------------------------
// dual_epsilon_greedy_bandit
// Exploration and exploitation epsilon-greedy bandits with a shared
// sequencer, one multiplier and one value table port.
// ----------------------------------------------------------------------------
// A cell-expanded word, or any word that is ignored, is taken without a stall.
// A random pick runs PICK and DONE; a greedy pick runs PICK, SCAN and DONE,
// and the argmax scan reads one table entry per cycle through the single
// table port. A size check that settles a pending round first updates two
// entries before its pick: each update runs 5 steps through the shared
// 24 x 24 multiplier, and the step decay takes 2 more. The input stalls while
// a word is in work; a finished word waits in the output register, and the
// next input word is taken meanwhile.
module dual_epsilon_greedy_bandit
  import deg_pkg::*;
#(
  parameter int unsigned NUM_ARMS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      command_i,
  input  logic            buffer_empty_i,
  input  logic [15:0]     random_draw_i,
  input  logic [2:0]      random_action_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [2:0]      chosen_action_o,
  output logic            which_table_o,
  output logic            was_greedy_o
);

  localparam int unsigned AW = (NUM_ARMS > 1) ? $clog2(NUM_ARMS) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(NUM_ARMS - 1);

  function automatic logic [AW-1:0] act_mod(input logic [2:0] r);
    logic [AW-1:0] res;
    res = '0;
    for (int k = 0; k < 8; k++) begin
      if (r == 3'(k)) res = AW'(k % NUM_ARMS);
    end
    return res;
  endfunction

  deg_state_e state_q, state_d;

  logic [StepW-1:0] decay_q, step_now_q;
  logic [EpsW-1:0]  eps_q;
  logic [CntW-1:0]  cell_q;
  logic [AW-1:0]    explore_choice_q, exploit_choice_q;
  logic             change_pending_q, round_pending_q;

  logic             tbl_q, greedy_q;
  logic [2:0]       ract_q;
  logic [AW-1:0]    scan_idx_q, best_idx_q;
  logic [ValW-1:0]  best_val_q, val_q;
  logic             neg_q;
  logic [41:0]      mag_q;
  logic [23:0]      lo_q;
  logic [42:0]      sum_q;

  logic             out_valid_q, out_tbl_q, out_greedy_q;
  logic [2:0]       out_act_q;

  logic             accept, out_free;
  logic             mul_en, vt_we, use_choice;
  logic [MulW-1:0]  mul_a, mul_b;
  logic [2*MulW-1:0] mul_p;
  logic [AW-1:0]    vt_idx;
  logic [ValW-1:0]  vt_rdata, vt_wdata;
  logic [41:0]      reward;
  logic [41:0]      diff;
  logic [43:0]      upd_sum;
  logic             rd_better;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (command_i == CmdSizeCheck && buffer_empty_i) begin
            state_d = round_pending_q ? ST_UPD_RD : ST_PICK;
          end else if (command_i == CmdChangeCheck && change_pending_q) begin
            state_d = ST_PICK;
          end
        end
      end
      ST_UPD_RD:    state_d = ST_UPD_MLO;
      ST_UPD_MLO:   state_d = ST_UPD_MHI;
      ST_UPD_MHI:   state_d = ST_UPD_SUM;
      ST_UPD_SUM:   state_d = ST_UPD_WR;
      ST_UPD_WR:    state_d = (tbl_q == TblExplore) ? ST_UPD_RD : ST_DECAY_MUL;
      ST_DECAY_MUL: state_d = ST_DECAY_WR;
      ST_DECAY_WR:  state_d = ST_PICK;
      ST_PICK:      state_d = greedy_q ? ST_SCAN : ST_DONE;
      ST_SCAN:      state_d = (scan_idx_q == LastIdx) ? ST_DONE : ST_SCAN;
      ST_DONE:      state_d = out_free ? ST_IDLE : ST_DONE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    mul_en     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    vt_we      = 1'b0;
    use_choice = 1'b0;
    case (state_q)
      ST_UPD_RD: use_choice = 1'b1;
      ST_UPD_MLO: begin
        use_choice = 1'b1;
        mul_en     = 1'b1;
        mul_a      = mag_q[23:0];
        mul_b      = step_now_q;
      end
      ST_UPD_MHI: begin
        use_choice = 1'b1;
        mul_en     = 1'b1;
        mul_a      = MulW'(mag_q[41:24]);
        mul_b      = step_now_q;
      end
      ST_UPD_SUM: use_choice = 1'b1;
      ST_UPD_WR: begin
        use_choice = 1'b1;
        vt_we      = 1'b1;
      end
      ST_DECAY_MUL: begin
        mul_en = 1'b1;
        mul_a  = step_now_q;
        mul_b  = decay_q;
      end
      default: begin
      end
    endcase
  end

  assign vt_idx = use_choice ?
                  ((tbl_q == TblExplore) ? explore_choice_q : exploit_choice_q) :
                  scan_idx_q;

  // The reward is minus the cell count in Q24.16. Once the count reaches
  // half its range, the reward sits at the most negative table value.
  assign reward = cell_q[CntW-1] ? {3'b111, 39'd0} : (42'd0 - {2'b00, cell_q, 16'd0});
  assign diff   = reward - {{2{vt_rdata[ValW-1]}}, vt_rdata};

  assign upd_sum = neg_q ?
                   ($signed({{4{val_q[ValW-1]}}, val_q}) - $signed({1'b0, sum_q})) :
                   ($signed({{4{val_q[ValW-1]}}, val_q}) + $signed({1'b0, sum_q}));

  always_comb begin
    if (upd_sum[43:39] == 5'b00000 || upd_sum[43:39] == 5'b11111) begin
      vt_wdata = upd_sum[ValW-1:0];
    end else if (upd_sum[43]) begin
      vt_wdata = {1'b1, {(ValW-1){1'b0}}};
    end else begin
      vt_wdata = {1'b0, {(ValW-1){1'b1}}};
    end
  end

  assign rd_better = (scan_idx_q == '0) || ($signed(vt_rdata) > $signed(best_val_q));

  deg_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  deg_vtab #(
    .NUM_ARMS (NUM_ARMS)
  ) u_vtab (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tbl_i   (tbl_q),
    .idx_i   (vt_idx),
    .we_i    (vt_we),
    .wdata_i (vt_wdata),
    .rdata_o (vt_rdata)
  );

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      eps_q            <= ExploreRst;
      decay_q          <= DecayRst;
      step_now_q       <= InitStepRst;
      cell_q           <= '0;
      explore_choice_q <= '0;
      exploit_choice_q <= '0;
      change_pending_q <= 1'b0;
      round_pending_q  <= 1'b0;
      tbl_q            <= TblExplore;
      scan_idx_q       <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgInitialStep: begin
            step_now_q <= cfg_data_i[StepW-1:0];
          end
          CfgExploreThreshold: eps_q   <= cfg_data_i[EpsW-1:0];
          CfgStepDecay:        decay_q <= cfg_data_i[StepW-1:0];
          default: begin
          end
        endcase
      end

      if (accept) begin
        tbl_q <= (command_i == CmdChangeCheck) ? TblExploit : TblExplore;
        if (command_i == CmdExpand) begin
          cell_q <= (cell_q >= CellCountMax - 1'b1) ? CellCountMax : cell_q + CellCountInc;
        end
      end

      if (state_q == ST_UPD_WR) begin
        tbl_q <= TblExploit;
      end

      if (state_q == ST_DECAY_WR) begin
        step_now_q      <= mul_p[2*MulW-1:MulW];
        cell_q          <= '0;
        round_pending_q <= 1'b0;
        tbl_q           <= TblExplore;
      end

      if (state_q == ST_PICK) begin
        scan_idx_q <= '0;
      end else if (state_q == ST_SCAN && scan_idx_q != LastIdx) begin
        scan_idx_q <= scan_idx_q + 1'b1;
      end

      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
        if (tbl_q == TblExplore) begin
          explore_choice_q <= best_idx_q;
          change_pending_q <= 1'b1;
        end else begin
          exploit_choice_q <= best_idx_q;
          change_pending_q <= 1'b0;
          round_pending_q  <= 1'b1;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      greedy_q <= (random_draw_i > eps_q);
      ract_q   <= random_action_i;
    end
    if (state_q == ST_UPD_RD) begin
      val_q <= vt_rdata;
      neg_q <= diff[41];
      mag_q <= diff[41] ? (42'd0 - diff) : diff;
    end
    if (state_q == ST_UPD_MHI) begin
      lo_q <= mul_p[2*MulW-1:MulW];
    end
    if (state_q == ST_UPD_SUM) begin
      sum_q <= 43'(mul_p) + 43'(lo_q);
    end
    if (state_q == ST_PICK && !greedy_q) begin
      best_idx_q <= act_mod(ract_q);
    end
    if (state_q == ST_SCAN && rd_better) begin
      best_idx_q <= scan_idx_q;
      best_val_q <= vt_rdata;
    end
    if (state_q == ST_DONE && out_free) begin
      out_act_q    <= 3'(best_idx_q);
      out_tbl_q    <= tbl_q;
      out_greedy_q <= greedy_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign chosen_action_o = out_act_q;
  assign which_table_o   = out_tbl_q;
  assign was_greedy_o    = out_greedy_q;

endmodule

// ----- design/deg_mul.sv -----
// ----------------------------------------------------------------------------
// deg_mul
// Shared unsigned multiplier with a registered product, used for both the
// value update and the step decay.
// ----------------------------------------------------------------------------
module deg_mul
  import deg_pkg::*;
(
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [MulW-1:0]     a_i,
  input  logic [MulW-1:0]     b_i,
  output logic [2*MulW-1:0]   p_o
);

  logic [2*MulW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

// ----- design/deg_vtab.sv -----
// ----------------------------------------------------------------------------
// deg_vtab
// Value tables of both bandits, one shared address for read and write.
// ----------------------------------------------------------------------------
module deg_vtab
  import deg_pkg::*;
#(
  parameter int unsigned NUM_ARMS = 8,
  localparam int unsigned AW = (NUM_ARMS > 1) ? $clog2(NUM_ARMS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tbl_i,
  input  logic [AW-1:0]   idx_i,
  input  logic            we_i,
  input  logic [ValW-1:0] wdata_i,
  output logic [ValW-1:0] rdata_o
);

  logic [ValW-1:0] explore_q [NUM_ARMS];
  logic [ValW-1:0] exploit_q [NUM_ARMS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ARMS; i++) begin
        explore_q[i] <= '0;
        exploit_q[i] <= '0;
      end
    end else if (we_i) begin
      if (tbl_i == TblExploit) begin
        exploit_q[idx_i] <= wdata_i;
      end else begin
        explore_q[idx_i] <= wdata_i;
      end
    end
  end

  assign rdata_o = (tbl_i == TblExploit) ? exploit_q[idx_i] : explore_q[idx_i];

endmodule

// ----- design/deg_chk.sv -----
// ----------------------------------------------------------------------------
// deg_chk
// Port-level checks of the dual epsilon-greedy bandit, bound to its top.
// ----------------------------------------------------------------------------
module deg_chk
  import deg_pkg::*;
#(
  parameter int unsigned NUM_ARMS = 8
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] command_i,
  input logic       buffer_empty_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] chosen_action_o,
  input logic       which_table_o,
  input logic       was_greedy_o
);

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(chosen_action_o) && $stable(which_table_o) &&
      $stable(was_greedy_o))
    else $error("stalled result word changed");

  // A size check on an empty buffer always starts a pick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && command_i == CmdSizeCheck && buffer_empty_i |=> in_stall_o)
    else $error("size check did not start a pick");

  // A cell-expanded word finishes in its own cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && command_i == CmdExpand |=> !in_stall_o)
    else $error("cell-expanded word kept the block busy");

  // Every reported action lies inside the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({2'b00, chosen_action_o} < 5'(NUM_ARMS)))
    else $error("chosen action out of range");

endmodule

bind dual_epsilon_greedy_bandit deg_chk #(
  .NUM_ARMS (NUM_ARMS)
) u_deg_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .command_i       (command_i),
  .buffer_empty_i  (buffer_empty_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .chosen_action_o (chosen_action_o),
  .which_table_o   (which_table_o),
  .was_greedy_o    (was_greedy_o)
);

// ----- verif/bandit_pick_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bandit_pick_checker
// Watches the configuration port and both word channels of the dual
// epsilon-greedy bandit, keeps its own copy of both value tables, and checks
// every output word against the pick it predicts.
// ----------------------------------------------------------------------------
module bandit_pick_checker
  import deg_pkg::*;
#(
  parameter int unsigned NUM_ARMS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  logic [1:0]      command_i,
  input  logic            buffer_empty_i,
  input  logic [15:0]     random_draw_i,
  input  logic [2:0]      random_action_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  logic [2:0]      chosen_action_i,
  input  logic            which_table_i,
  input  logic            was_greedy_i,
  output int              error_count_o,
  output int              pending_o
);

  typedef struct packed {
    logic [2:0] action;
    logic       tbl_sel;
    logic       greedy;
  } pick_t;

  localparam longint ValMax = 64'sh7F_FFFF_FFFF;
  localparam longint ValMin = -64'sh80_0000_0000;

  logic [StepW-1:0]       step_decay;
  logic [StepW-1:0]       step_now;
  logic [EpsW-1:0]        epsilon;
  logic signed [ValW-1:0] explore_vals [NUM_ARMS];
  logic signed [ValW-1:0] exploit_vals [NUM_ARMS];
  logic [CntW-1:0]        cells;
  logic [2:0]             explore_sel;
  logic [2:0]             exploit_sel;
  logic                   change_armed;
  logic                   round_armed;
  pick_t                  expected_picks [$];
  int                     errs = 0;

  function automatic longint clamp_value(longint v);
    if (v > ValMax) return ValMax;
    if (v < ValMin) return ValMin;
    return v;
  endfunction

  // Moves one entry toward the reward by the current step, rounding the
  // step's share of the distance toward zero.
  function automatic logic signed [ValW-1:0] nudge(logic signed [ValW-1:0] entry,
                                                   longint reward,
                                                   logic [StepW-1:0] step);
    longint      diff;
    logic [63:0] mag;
    logic [63:0] prod;
    diff = reward - longint'(entry);
    mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
    prod = (mag >> 24) * 64'(step) + (((mag & 64'hFF_FFFF) * 64'(step)) >> 24);
    return ValW'(clamp_value((diff < 0) ? longint'(entry) - longint'(prod)
                                        : longint'(entry) + longint'(prod)));
  endfunction

  function automatic pick_t choose(logic tbl, logic [EpsW-1:0] draw, logic [2:0] ract);
    pick_t p;
    int    best;
    p.tbl_sel = tbl;
    if (draw > epsilon) begin
      best = 0;
      for (int i = 1; i < NUM_ARMS; i++) begin
        if (tbl == TblExploit ? exploit_vals[i] > exploit_vals[best]
                              : explore_vals[i] > explore_vals[best]) begin
          best = i;
        end
      end
      p.action = 3'(best);
      p.greedy = 1'b1;
    end else begin
      p.action = 3'(ract % NUM_ARMS);
      p.greedy = 1'b0;
    end
    return p;
  endfunction

  task automatic take_event(logic [1:0] cmd, logic empty, logic [15:0] draw,
                            logic [2:0] ract);
    longint reward;
    pick_t  p;
    case (cmd)
      CmdExpand: begin
        cells = (cells >= CellCountMax - 1'b1) ? CellCountMax : cells + CellCountInc;
      end
      CmdSizeCheck: begin
        if (empty) begin
          if (round_armed) begin
            reward = clamp_value(-(longint'(cells) * 65536));
            explore_vals[explore_sel % NUM_ARMS] =
              nudge(explore_vals[explore_sel % NUM_ARMS], reward, step_now);
            exploit_vals[exploit_sel % NUM_ARMS] =
              nudge(exploit_vals[exploit_sel % NUM_ARMS], reward, step_now);
            cells       = '0;
            round_armed = 1'b0;
            step_now    = StepW'((64'(step_now) * 64'(step_decay)) >> 24);
          end
          p = choose(TblExplore, draw, ract);
          explore_sel  = p.action;
          change_armed = 1'b1;
          expected_picks.push_back(p);
        end
      end
      CmdChangeCheck: begin
        if (change_armed) begin
          p = choose(TblExploit, draw, ract);
          exploit_sel  = p.action;
          change_armed = 1'b0;
          round_armed  = 1'b1;
          expected_picks.push_back(p);
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errs++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pick_t want;
    if (!rst_ni) begin
      step_now     = InitStepRst;
      epsilon      = ExploreRst;
      step_decay   = DecayRst;
      cells        = '0;
      explore_sel  = '0;
      exploit_sel  = '0;
      change_armed = 1'b0;
      round_armed  = 1'b0;
      for (int i = 0; i < NUM_ARMS; i++) begin
        explore_vals[i] = '0;
        exploit_vals[i] = '0;
      end
      expected_picks.delete();
    end else begin
      // The output side goes first: a word taken at this edge cannot be
      // answered at the same edge.
      if (out_valid_i && !out_stall_i) begin
        if (expected_picks.size() == 0) begin
          errs++;
          $display("%0t: unexpected word, action %0d table %0d greedy %0d", $time,
                   chosen_action_i, which_table_i, was_greedy_i);
        end else begin
          want = expected_picks.pop_front();
          check_field("chosen_action", want.action, chosen_action_i);
          check_field("which_table", want.tbl_sel, which_table_i);
          check_field("was_greedy", want.greedy, was_greedy_i);
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgInitialStep: begin
            step_now = cfg_data_i[StepW-1:0];
          end
          CfgExploreThreshold: epsilon = cfg_data_i[EpsW-1:0];
          CfgStepDecay: step_decay = cfg_data_i[StepW-1:0];
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        take_event(command_i, buffer_empty_i, random_draw_i, random_action_i);
      end
    end
    error_count_o <= errs;
    pending_o     <= expected_picks.size();
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the dual epsilon-greedy bandit with a directed opening and random
// rounds of expand, size-check and change-check words under several register
// settings, with random idling on both channels, and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
  import deg_pkg::*;

  localparam int unsigned NumArms      = 8;
  localparam int          SettleCycles = 30;
  localparam int          HoldCycles   = 300;
  localparam int          PhaseWords   = 180;
  localparam logic [1:0]  CmdUnused    = 2'd3;
  localparam logic [1:0]  CfgUnused    = 2'd3;

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic [1:0]      cfg_index;
  logic [CfgW-1:0] cfg_data;
  logic            in_valid;
  logic            in_stall;
  logic [1:0]      command;
  logic            buffer_empty;
  logic [15:0]     random_draw;
  logic [2:0]      random_action;
  logic            out_valid;
  logic            out_stall;
  logic [2:0]      chosen_action;
  logic            which_table;
  logic            was_greedy;
  int              error_count;
  int              pending;

  bit              tx_idle;
  bit              rx_idle;
  bit              hold_req;
  logic [15:0]     cur_eps;

  dual_epsilon_greedy_bandit #(
    .NUM_ARMS(NumArms)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .buffer_empty_i (buffer_empty),
    .random_draw_i  (random_draw),
    .random_action_i(random_action),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .chosen_action_o(chosen_action),
    .which_table_o  (which_table),
    .was_greedy_o   (was_greedy)
  );

  bandit_pick_checker #(
    .NUM_ARMS(NumArms)
  ) checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .command_i      (command),
    .buffer_empty_i (buffer_empty),
    .random_draw_i  (random_draw),
    .random_action_i(random_action),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .chosen_action_i(chosen_action),
    .which_table_i  (which_table),
    .was_greedy_i   (was_greedy),
    .error_count_o  (error_count),
    .pending_o      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

  // Offers one word and returns at the edge where it is taken. Valid stays
  // high into the next word when no gap is drawn.
  task automatic send_word(logic [1:0] cmd, logic empty, logic [15:0] draw,
                           logic [2:0] act);
    int gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    buffer_empty  <= empty;
    random_draw   <= draw;
    random_action <= act;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_regs(logic [StepW-1:0] step, logic [EpsW-1:0] eps,
                            logic [StepW-1:0] decay, bit poke_unused);
    cfg_we    <= 1'b1;
    cfg_index <= CfgInitialStep;
    cfg_data  <= step;
    @(posedge clk);
    // Upper data bits are junk for the 16-bit register.
    cfg_index <= CfgExploreThreshold;
    cfg_data  <= {8'($urandom), eps};
    @(posedge clk);
    cfg_index <= CfgStepDecay;
    cfg_data  <= decay;
    @(posedge clk);
    if (poke_unused) begin
      cfg_index <= CfgUnused;
      cfg_data  <= CfgW'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_eps = eps;
    @(posedge clk);
  endtask

  // Draws cluster around epsilon now and then so both sides of the compare
  // are hit.
  function automatic logic [15:0] next_draw();
    if ($urandom_range(0, 3) == 0) return cur_eps + 16'($urandom_range(0, 2)) - 16'd1;
    return 16'($urandom);
  endfunction

  task automatic run_rounds(int budget);
    int sent;
    int n;
    sent = 0;
    while (sent < budget) begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 5);
      repeat (n) send_word(CmdExpand, 1'($urandom), 16'($urandom), 3'($urandom));
      sent += n;
      if ($urandom_range(0, 7) == 0) begin
        send_word(2'($urandom), 1'($urandom), next_draw(), 3'($urandom));
      end
      send_word(CmdSizeCheck, 1'b1, next_draw(), 3'($urandom));
      sent++;
      if ($urandom_range(0, 7) != 0) begin
        send_word(CmdChangeCheck, 1'($urandom), next_draw(), 3'($urandom));
        sent++;
      end
    end
  endtask

  task automatic run_phase(logic [StepW-1:0] step, logic [EpsW-1:0] eps,
                           logic [StepW-1:0] decay, bit poke_unused, bit idle_tx,
                           bit idle_rx);
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    write_regs(step, eps, decay, poke_unused);
    tx_idle = idle_tx;
    rx_idle = idle_rx;
    run_rounds(PhaseWords);
  endtask

  // Receiver: a random stall before each word while receive idling is on, and
  // one long hold-off on request.
  initial begin
    int n;
    bit held;
    held      = 1'b0;
    out_stall = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        held = 1'b1;
      end
      n = rx_idle ? $urandom_range(0, 3) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CfgInitialStep;
    cfg_data      = '0;
    in_valid      = 1'b0;
    command       = CmdExpand;
    buffer_empty  = 1'b0;
    random_draw   = '0;
    random_action = '0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    hold_req      = 1'b0;
    cur_eps       = ExploreRst;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening words run on the reset register values.
    send_word(CmdChangeCheck, 1'b1, 16'hFFFF, 3'd7);  // no pick before it
    send_word(CmdUnused, 1'b1, 16'hFFFF, 3'd7);
    send_word(CmdSizeCheck, 1'b0, 16'hFFFF, 3'd7);    // buffer not empty
    send_word(CmdSizeCheck, 1'b1, 16'h0000, 3'd7);
    send_word(CmdChangeCheck, 1'b0, 16'hFFFF, 3'd0);  // all-zero table, tie
    send_word(CmdExpand, 1'b0, 16'h0000, 3'd0);
    send_word(CmdExpand, 1'b1, 16'hFFFF, 3'd7);
    send_word(CmdExpand, 1'b0, 16'h5555, 3'd2);
    send_word(CmdSizeCheck, 1'b1, ExploreRst, 3'd5);  // draw equal to epsilon
    send_word(CmdChangeCheck, 1'b1, ExploreRst + 16'd1, 3'd4);
    send_word(CmdSizeCheck, 1'b1, 16'hFFFF, 3'd1);
    send_word(CmdChangeCheck, 1'b0, 16'h0000, 3'd0);
    send_word(CmdExpand, 1'b1, 16'hAAAA, 3'd5);
    send_word(CmdExpand, 1'b0, 16'h1234, 3'd6);
    send_word(CmdSizeCheck, 1'b0, 16'hFFFF, 3'd3);    // pending round stays
    send_word(CmdSizeCheck, 1'b1, 16'd40000, 3'd3);
    send_word(CmdChangeCheck, 1'b1, 16'd1, 3'd6);
    send_word(CmdChangeCheck, 1'b1, 16'hFFFF, 3'd2);  // already answered
    send_word(CmdUnused, 1'b0, 16'h0000, 3'd0);

    run_phase(24'hFF_FFFF, 16'h0000, 24'hFF_FFFF, 1'b0, 1'b1, 1'b1);
    run_phase(24'h00_0000, 16'hFFFF, 24'h00_0000, 1'b1, 1'b0, 1'b0);

    // Long hold on the output while words keep coming, then a full drain and more rounds.
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    write_regs(24'($urandom), 16'($urandom), 24'($urandom), 1'b0);
    tx_idle = 1'b1;
    rx_idle = 1'b0;
    hold_req <= 1'b1;
    run_rounds(PhaseWords / 2);
    wait_drained();
    run_rounds(PhaseWords / 2);

    run_phase(24'h80_0000, 16'h8000, 24'h00_0000, 1'b0, 1'b1, 1'b1);
    run_phase(InitStepRst, ExploreRst, DecayRst, 1'b1, 1'b0, 1'b0);
    run_phase(24'($urandom), 16'($urandom_range(0, 8000)), 24'($urandom), 1'b0, 1'b1, 1'b1);
    run_phase(24'hFF_FFFF, 16'h0001, 24'hFF_FFFF, 1'b0, 1'b0, 1'b1);
    run_phase(24'($urandom), 16'($urandom), 24'hF0_0000, 1'b1, 1'b1, 1'b1);

    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
